// ===== rtl/rllt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rllt_pkg: shared types and constants of the run-length line table
// Holds the table sizes, the run entry layout, the result status codes and
// the structs that pass between the controller and the run store.
// ----------------------------------------------------------------------------
package rllt_pkg;

	// Table capacity.
	localparam int unsigned MAX_RUNS    = 256;
	localparam int unsigned RUN_AW      = $clog2(MAX_RUNS);
	localparam int unsigned RUN_CW      = RUN_AW + 1;
	localparam int unsigned MAX_BYTES   = 65536;
	localparam int unsigned BYTE_CW     = $clog2(MAX_BYTES) + 1;
	localparam int unsigned STEP_W      = $clog2(RUN_AW + 1);

	// Field widths.
	localparam int unsigned LINE_BITS   = 16;
	localparam int unsigned OFFSET_BITS = 16;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	// Operation codes carried in the input tuser.
	typedef enum logic {
		OP_APPEND = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	// One run: its first byte offset and its line.
	typedef struct packed {
		logic [LINE_BITS-1:0]   line;
		logic [OFFSET_BITS-1:0] start;
	} entry_t;

	// Access to the run store for one cycle.
	typedef struct packed {
		logic              we;
		logic [RUN_AW-1:0] waddr;
		entry_t            wdata;
		logic [RUN_AW-1:0] raddr;
	} mem_req_t;

	// Result handed from the controller to the output register.
	typedef struct packed {
		logic                 valid;
		logic [LINE_BITS-1:0] line;
		status_t              status;
	} res_t;

endpackage

// ===== rtl/run_length_line_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_length_line_table: byte offset to source line table
// Run-length table of (start offset, line) entries with binary-search lookup.
// ----------------------------------------------------------------------------
// Appends stream at one per clock while the result side keeps up. A lookup
// walks the table with one binary-search probe per cycle through the single
// read port of the run store (run zero, then one probe for each of the eight
// address bits). The next item is taken only once the search is back in idle,
// so the input takes no new item while a lookup runs. Every item gives exactly
// one result. Lookup on an empty table answers status 1; an append past 65536
// bytes or 256 runs is dropped with status 2. The store needs no clearing
// after reset.
module run_length_line_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] line_number, [31:16] query_offset
	input  logic        s_tuser,   // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [15:0] found_line, [17:16] status, [23:18] zero
);
	import rllt_pkg::*;

	res_t     res;
	mem_req_t mem_req;
	entry_t   rd_entry;
	logic     out_free;

	logic                 m_valid_q;
	logic [LINE_BITS-1:0] m_line_q;
	status_t              m_status_q;

	assign out_free = !m_valid_q || m_tready;

	rllt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (s_tuser),
		.in_line  (s_tdata[15:0]),
		.in_query (s_tdata[31:16]),
		.out_free (out_free),
		.res      (res),
		.mem_req  (mem_req),
		.rd_entry (rd_entry)
	);

	rllt_run_store u_store (
		.clk      (clk),
		.req      (mem_req),
		.rd_entry (rd_entry)
	);

	// Output register: holds a result until the downstream transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res.valid) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			m_line_q   <= res.line;
			m_status_q <= res.status;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'b0, m_status_q, m_line_q};

	// A new result never overwrites one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> out_free)
		else $error("result overwrote a pending result");

endmodule

// ===== rtl/rllt_run_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rllt_run_store: storage of the run entries
// Single synchronous memory with one write port and one read port. Read data
// appears in the cycle after the address. Entries are undefined until written.
// ----------------------------------------------------------------------------
module rllt_run_store (
	input  logic              clk,
	input  rllt_pkg::mem_req_t req,
	output rllt_pkg::entry_t  rd_entry
);
	import rllt_pkg::*;

	entry_t mem [MAX_RUNS];

	// Write port.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rd_entry <= mem[req.raddr];
	end

endmodule

// ===== rtl/rllt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rllt_ctrl: append and binary-search sequencer
// Counts appended bytes, opens runs in the store and walks the store with a
// bit-by-bit binary search for lookups, one memory probe per cycle.
// ----------------------------------------------------------------------------
module rllt_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                in_op,
	input  logic [rllt_pkg::LINE_BITS-1:0]      in_line,
	input  logic [rllt_pkg::OFFSET_BITS-1:0]    in_query,
	input  logic                                out_free,
	output rllt_pkg::res_t                      res,
	output rllt_pkg::mem_req_t                  mem_req,
	input  rllt_pkg::entry_t                    rd_entry
);
	import rllt_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;

	state_t                 state_q;
	logic [BYTE_CW-1:0]     byte_total_q;
	logic [RUN_CW-1:0]      run_total_q;
	logic [LINE_BITS-1:0]   last_line_q;
	logic [OFFSET_BITS-1:0] query_q;
	logic [RUN_AW-1:0]      idx_q;
	logic [RUN_AW-1:0]      cand_q;
	logic                   cand_ok_q;
	logic [STEP_W-1:0]      bit_q;
	logic [LINE_BITS-1:0]   best_line_q;

	logic                   accept;
	logic                   is_lookup;
	logic                   same_line;
	logic                   byte_full;
	logic                   run_full;
	logic                   drop;
	logic                   open_run;
	logic                   take;
	logic [RUN_AW-1:0]      new_idx;
	logic [LINE_BITS-1:0]   new_line;
	logic [RUN_AW-1:0]      next_cand;
	logic                   next_cand_ok;
	logic                   last_step;

	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign is_lookup = (in_op == OP_LOOKUP);

	// Append decision against the counters and the cached last line.
	assign same_line = (run_total_q != '0) && (last_line_q == in_line);
	assign byte_full = (byte_total_q >= BYTE_CW'(MAX_BYTES));
	assign run_full  = (run_total_q >= RUN_CW'(MAX_RUNS));
	assign drop      = byte_full || (!same_line && run_full);
	assign open_run  = !drop && !same_line;

	// One search step: keep the probed run if it starts at or below the query.
	assign take      = cand_ok_q && (rd_entry.start <= query_q);
	assign new_idx   = take ? cand_q : idx_q;
	assign new_line  = take ? rd_entry.line : best_line_q;
	assign last_step = (bit_q == '0);
	assign next_cand = new_idx | (RUN_AW'(1) << (bit_q - STEP_W'(1)));
	assign next_cand_ok = ({1'b0, next_cand} < run_total_q);

	// Memory access and result for this cycle.
	always_comb begin
		mem_req.we          = accept && !is_lookup && open_run;
		mem_req.waddr       = run_total_q[RUN_AW-1:0];
		mem_req.wdata.line  = in_line;
		mem_req.wdata.start = byte_total_q[OFFSET_BITS-1:0];
		mem_req.raddr       = (state_q == ST_SEARCH) ? next_cand : '0;

		res.valid  = 1'b0;
		res.line   = '0;
		res.status = STATUS_OK;
		if (state_q == ST_SEARCH) begin
			res.valid = last_step;
			res.line  = new_line;
		end else if (accept) begin
			if (!is_lookup) begin
				res.valid  = 1'b1;
				res.status = drop ? STATUS_FULL : STATUS_OK;
			end else if (run_total_q == '0) begin
				res.valid  = 1'b1;
				res.status = STATUS_EMPTY;
			end
		end
	end

	// State, counters and search registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			byte_total_q <= '0;
			run_total_q  <= '0;
			last_line_q  <= '0;
			query_q      <= '0;
			idx_q        <= '0;
			cand_q       <= '0;
			cand_ok_q    <= 1'b0;
			bit_q        <= '0;
			best_line_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && !is_lookup && !drop) begin
						byte_total_q <= byte_total_q + BYTE_CW'(1);
						if (open_run) begin
							run_total_q <= run_total_q + RUN_CW'(1);
							last_line_q <= in_line;
						end
					end
					// The first probe reads run zero, which always qualifies.
					if (accept && is_lookup && (run_total_q != '0)) begin
						state_q     <= ST_SEARCH;
						query_q     <= in_query;
						idx_q       <= '0;
						cand_q      <= '0;
						cand_ok_q   <= 1'b1;
						bit_q       <= STEP_W'(RUN_AW);
						best_line_q <= '0;
					end
				end
				ST_SEARCH: begin
					idx_q       <= new_idx;
					best_line_q <= new_line;
					cand_q      <= next_cand;
					cand_ok_q   <= next_cand_ok;
					if (last_step) begin
						state_q <= ST_IDLE;
					end else begin
						bit_q <= bit_q - STEP_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Every run holds at least one byte.
	a_runs_le_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		{{(BYTE_CW-RUN_CW){1'b0}}, run_total_q} <= byte_total_q)
		else $error("run count exceeds byte count");

	// A search only runs over a non-empty table.
	a_search_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (run_total_q != '0))
		else $error("search over an empty table");

	// Nothing is written to the store while a search is walking it.
	a_no_write_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> !mem_req.we)
		else $error("store written during a search");

endmodule
